// ===== rtl/bpdm_pkg.sv =====
// Package for the block power dB meter: widths, constants, item structs,
// controller state and the command/status bundles between ctrl and datapath.
// No dependencies.
`default_nettype none
package bpdm_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int SUM_BITS      = 48;
  localparam int LOG_FRAC_BITS = 6;

  // squared sample pair sum and accumulator add widths
  localparam int P_W   = 2 * SAMPLE_BITS + 1;
  localparam int ACC_W = ((P_W > SUM_BITS) ? P_W : SUM_BITS) + 1;

  // log2: mantissa normalized with its leading one at bit MANT_POS
  localparam int MANT_POS = 30;
  localparam int MANT_W   = MANT_POS + 1;
  localparam int MSB_W    = $clog2(SUM_BITS);
  localparam int LG_W     = MSB_W + LOG_FRAC_BITS;
  localparam int FC_W     = (LOG_FRAC_BITS > 1) ? $clog2(LOG_FRAC_BITS) : 1;

  // 16 * 10 * log10(2) in Q16
  localparam int          K_W               = 22;
  localparam logic [K_W-1:0] DB16_PER_LOG2_Q16 = K_W'(3156528);
  localparam int          SCALE_SH          = 16 + LOG_FRAC_BITS;
  localparam int          PROD_W            = LG_W + K_W + 1;
  localparam int          DB_W              = PROD_W - SCALE_SH;
  localparam int          V_W               = ((DB_W > 13) ? DB_W : 13) + 2;

  localparam int LEVEL_MAX = 8191;
  localparam int LEVEL_MIN = -8192;

  // configuration register indexes
  localparam logic [0:0] CFG_CORRECTION  = 1'b0;
  localparam logic [0:0] CFG_BYTE_OFFSET = 1'b1;

  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               block_end;
  } sample_t;

  typedef struct packed {
    logic signed [13:0] level_db16;
    logic [7:0]         level_byte;
  } reading_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_NORM,
    ST_FRAC,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic norm_step;
    logic load_mant;
    logic frac_step;
    logic scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/bpdm_ctrl.sv =====
// Controller for the block power dB meter: sequences accumulate, normalize,
// fraction squaring, scaling and result load. Uses bpdm_pkg.
`default_nettype none
module bpdm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 sample_valid,
  input  wire                 block_end,
  output logic                sample_stall,
  input  bpdm_pkg::status_t   sts,
  output bpdm_pkg::cmd_t      cmd
);

  bpdm_pkg::state_t          state, state_next;
  logic [bpdm_pkg::FC_W-1:0] frac_cnt, frac_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpdm_pkg::ST_ACC;
      frac_cnt <= '0;
    end else begin
      state    <= state_next;
      frac_cnt <= frac_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    frac_cnt_next = frac_cnt;
    cmd           = '0;
    sample_stall  = 1'b1;
    case (state)
      bpdm_pkg::ST_ACC: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          if (block_end) state_next = bpdm_pkg::ST_NORM;
        end
      end
      bpdm_pkg::ST_NORM: begin
        if (sts.norm_done) begin
          cmd.load_mant = 1'b1;
          frac_cnt_next = '0;
          state_next    = bpdm_pkg::ST_FRAC;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      bpdm_pkg::ST_FRAC: begin
        cmd.frac_step = 1'b1;
        frac_cnt_next = frac_cnt + 1'b1;
        if (frac_cnt == bpdm_pkg::FC_W'(bpdm_pkg::LOG_FRAC_BITS - 1))
          state_next = bpdm_pkg::ST_SCALE;
      end
      bpdm_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = bpdm_pkg::ST_DONE;
      end
      bpdm_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = bpdm_pkg::ST_ACC;
        end
      end
      default: begin
        state_next = bpdm_pkg::ST_ACC;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bpdm_datapath.sv =====
// Datapath for the block power dB meter: power accumulator, leading-one
// normalizer, squaring log2 unit, dB scaler and output register.
// Uses bpdm_pkg; driven by bpdm_ctrl.
`default_nettype none
module bpdm_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  bpdm_pkg::sample_t    sample,
  input  bpdm_pkg::cmd_t       cmd,
  output bpdm_pkg::status_t    sts,
  input  wire                  cfg_we,
  input  wire  [0:0]           cfg_index,
  input  wire  [12:0]          cfg_data,
  output logic                 reading_valid,
  input  wire                  reading_stall,
  output bpdm_pkg::reading_t   reading
);

  localparam int S = bpdm_pkg::SAMPLE_BITS;

  logic signed [12:0] correction_db16;
  logic [7:0]         byte_offset_db;

  // accumulator
  logic [bpdm_pkg::SUM_BITS-1:0] power_sum, sat_sum;
  logic signed [S-1:0]           iv, qv;
  logic signed [2*S-1:0]         isq, qsq;
  logic [bpdm_pkg::P_W-1:0]      p;
  logic [bpdm_pkg::ACC_W-1:0]    acc_sum;

  // log2 and scaling
  logic [bpdm_pkg::SUM_BITS-1:0] norm;
  logic [bpdm_pkg::MSB_W-1:0]    shcnt, msb;
  logic [bpdm_pkg::MANT_W-1:0]   x;
  logic [2*bpdm_pkg::MANT_W-1:0] sq;
  logic [bpdm_pkg::MANT_W:0]     t;
  logic [bpdm_pkg::LG_W-1:0]     lg;
  logic [bpdm_pkg::PROD_W-1:0]   prod;
  logic [bpdm_pkg::DB_W-1:0]     db;
  logic                          norm_zero;

  // final reading
  logic signed [bpdm_pkg::V_W-1:0] v;
  logic signed [13:0]              level;
  logic signed [14:0]              lvx, pos, negm;
  logic signed [10:0]              whole;
  logic signed [11:0]              b;
  logic [7:0]                      byte_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      correction_db16 <= '0;
      byte_offset_db  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpdm_pkg::CFG_CORRECTION:  correction_db16 <= cfg_data;
        bpdm_pkg::CFG_BYTE_OFFSET: byte_offset_db  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign iv      = S'(sample.i_sample);
  assign qv      = S'(sample.q_sample);
  assign isq     = iv * iv;
  assign qsq     = qv * qv;
  assign p       = {1'b0, isq} + {1'b0, qsq};
  assign acc_sum = bpdm_pkg::ACC_W'(power_sum) + bpdm_pkg::ACC_W'(p);
  assign sat_sum = (acc_sum[bpdm_pkg::ACC_W-1:bpdm_pkg::SUM_BITS] != '0) ? '1
                 : acc_sum[bpdm_pkg::SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      power_sum <= '0;
    end else if (cmd.accept) begin
      power_sum <= sample.block_end ? '0 : sat_sum;
    end
  end

  // normalizer: shift left until the leading one reaches the top bit
  assign norm_zero     = (norm == '0);
  assign sts.norm_done = norm[bpdm_pkg::SUM_BITS-1] || norm_zero;
  assign msb           = bpdm_pkg::MSB_W'(bpdm_pkg::SUM_BITS - 1) - shcnt;

  always_ff @(posedge clk) begin
    if (cmd.accept && sample.block_end) begin
      norm  <= sat_sum;
      shcnt <= '0;
    end else if (cmd.norm_step) begin
      norm  <= norm << 1;
      shcnt <= shcnt + 1'b1;
    end
  end

  // one fraction bit per squaring of the mantissa
  assign sq = (2*bpdm_pkg::MANT_W)'(x) * (2*bpdm_pkg::MANT_W)'(x);
  assign t  = sq[bpdm_pkg::MANT_POS +: bpdm_pkg::MANT_W+1];

  always_ff @(posedge clk) begin
    if (cmd.load_mant) begin
      x  <= norm[bpdm_pkg::SUM_BITS-1 -: bpdm_pkg::MANT_W];
      lg <= bpdm_pkg::LG_W'(msb);
    end else if (cmd.frac_step) begin
      x  <= t[bpdm_pkg::MANT_W] ? t[bpdm_pkg::MANT_W:1] : t[bpdm_pkg::MANT_W-1:0];
      lg <= {lg[bpdm_pkg::LG_W-2:0], t[bpdm_pkg::MANT_W]};
    end
  end

  // lg * 16*10*log10(2), rounded half up
  assign prod = bpdm_pkg::PROD_W'(lg) * bpdm_pkg::PROD_W'(bpdm_pkg::DB16_PER_LOG2_Q16)
              + (bpdm_pkg::PROD_W'(1) << (bpdm_pkg::SCALE_SH - 1));

  always_ff @(posedge clk) begin
    if (cmd.scale) db <= bpdm_pkg::DB_W'(prod >> bpdm_pkg::SCALE_SH);
  end

  always_comb begin
    v = $signed(bpdm_pkg::V_W'(db)) + bpdm_pkg::V_W'(correction_db16);
    if (norm_zero)
      level = 14'(bpdm_pkg::LEVEL_MIN);
    else if (v > bpdm_pkg::V_W'(bpdm_pkg::LEVEL_MAX))
      level = 14'(bpdm_pkg::LEVEL_MAX);
    else if (v < bpdm_pkg::V_W'(bpdm_pkg::LEVEL_MIN))
      level = 14'(bpdm_pkg::LEVEL_MIN);
    else
      level = v[13:0];
    // whole dB, half away from zero
    lvx   = 15'(level);
    pos   = lvx + 15'sd8;
    negm  = 15'sd8 - lvx;
    whole = level[13] ? -(11'(negm >>> 4)) : 11'(pos >>> 4);
    b     = 12'(whole) + $signed({4'b0, byte_offset_db});
    if (b < 12'sd0)
      byte_val = 8'd0;
    else if (b > 12'sd255)
      byte_val = 8'd255;
    else
      byte_val = b[7:0];
  end

  assign sts.out_free = !reading_valid || !reading_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_valid <= 1'b0;
    end else if (cmd.finish) begin
      reading_valid <= 1'b1;
    end else if (!reading_stall) begin
      reading_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      reading.level_db16 <= level;
      reading.level_byte <= byte_val;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/block_power_db_meter.sv =====
// Block power dB meter: I/Q power accumulator with a fixed-point 10*log10 reading.
// Top level; instantiates bpdm_ctrl and bpdm_datapath, uses bpdm_pkg.
//
// Usage:
//   sample channel (sample_valid/sample_stall/sample) carries one I/Q pair per item.
//   Items without block_end are summed into a saturating power accumulator at one
//   item per cycle. The item with block_end is summed, then the accumulator clears
//   and the reading is computed while sample_stall is high.
//   reading channel (reading_valid/reading_stall/reading) carries one item per block:
//   level_db16 in 1/16 dB plus correction, and the byte reading.
//   After the block_end item, the leading-one normalizer shifts the 48-bit sum left
//   one bit per cycle until its top bit is set (no shift for a zero sum), the log2
//   unit squares the mantissa once per fraction bit, the scaler registers the dB
//   value and the reading is loaded into the output register.
//   Input reopens in the same cycle as the reading shows valid.
//   A held reading waits in the output register; if it is still stalled when the
//   next block's reading is ready, that block holds in its last step.
//   Reset (rst, synchronous) clears the accumulator, the config registers to 0
//   and any pending reading. cfg_we writes cfg_data to register cfg_index
//   (0: correction_db16, 1: byte_offset_db); the user keeps to idle, not the block.
`default_nettype none
module block_power_db_meter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 sample_valid,
  output logic                sample_stall,
  input  bpdm_pkg::sample_t   sample,
  output logic                reading_valid,
  input  wire                 reading_stall,
  output bpdm_pkg::reading_t  reading,
  input  wire                 cfg_we,
  input  wire  [0:0]          cfg_index,
  input  wire  [12:0]         cfg_data
);

  bpdm_pkg::cmd_t    cmd;
  bpdm_pkg::status_t sts;

  bpdm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .block_end    (sample.block_end),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  bpdm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .reading       (reading)
  );

endmodule
`default_nettype wire

// ===== rtl/bpdm_checker.sv =====
// Port-level checker for the block power dB meter, bound to the top level.
// Uses bpdm_pkg types.
`default_nettype none
module bpdm_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 sample_valid,
  input wire                 sample_stall,
  input bpdm_pkg::sample_t   sample,
  input wire                 reading_valid,
  input wire                 reading_stall,
  input bpdm_pkg::reading_t  reading
);

  // a stalled reading holds
  a_reading_hold: assert property (@(posedge clk) disable iff (rst)
    reading_valid && reading_stall |=> reading_valid && $stable(reading))
    else $error("reading changed while stalled");

  // after a block end item the block is busy computing
  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && sample.block_end |=> sample_stall)
    else $error("sample accepted right after block end");

  // no reading straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !reading_valid)
    else $error("reading valid after reset");

  // a floor-level reading always gives a zero byte
  a_floor_byte: assert property (@(posedge clk) disable iff (rst)
    reading_valid && (reading.level_db16 == -14'sd8192) |-> reading.level_byte == 8'd0)
    else $error("floor reading with nonzero byte");

endmodule

bind block_power_db_meter bpdm_checker u_bpdm_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample_valid),
  .sample_stall  (sample_stall),
  .sample        (sample),
  .reading_valid (reading_valid),
  .reading_stall (reading_stall),
  .reading       (reading)
);
`default_nettype wire
